// ----- hdl/vsa_pkg.sv -----
// shared types and helpers for the vertex skinning accumulator
// command and status structs between controller and datapath, word layouts
// no dependencies
package vsa_pkg;

    localparam int S_DATA_W = 184;
    localparam int M_DATA_W = 192;

    // input word field offsets
    localparam int F_IDX    = 0;
    localparam int F_PX     = 7;
    localparam int F_PY     = 39;
    localparam int F_PZ     = 71;
    localparam int F_QW     = 103;
    localparam int F_QX     = 119;
    localparam int F_QY     = 135;
    localparam int F_QZ     = 151;
    localparam int F_BIAS   = 167;

    localparam int ACC_W    = 55;
    localparam int PROD_W   = 53;
    localparam int T_W      = 36;

    typedef enum logic [2:0] {
        A_QW, A_QX, A_QY, A_QZ, A_BIAS
    } a_sel_t;

    typedef enum logic [3:0] {
        B_PX, B_PY, B_PZ, B_TX, B_TY, B_TZ, B_VX, B_VY, B_VZ, B_WX, B_WY, B_WZ
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_NONE, ST_TX, ST_TY, ST_TZ, ST_WX, ST_WY, ST_WZ,
        ST_AVX, ST_AVY, ST_AVZ, ST_ANX, ST_ANY, ST_ANZ
    } store_t;

    typedef enum logic [1:0] {
        VS_NONE, VS_X, VS_Y, VS_Z
    } vsum_t;

    typedef struct packed {
        logic    write_joint;
        logic    load_item;
        logic    emit;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        store_t  store;
        vsum_t   vsum;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
        if (x > 42'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -42'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

// ----- hdl/vsa_ctrl.sv -----
// sequencer for the vertex skinning accumulator
// steps one shared multiply-accumulate through the rotation and bias terms
// depends on vsa_pkg
module vsa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_mode,
    input  logic             in_last,
    output logic             in_ready,
    input  vsa_pkg::dp_stat_t stat,
    output vsa_pkg::dp_cmd_t  cmd
);
    import vsa_pkg::*;

    localparam int LAST_STEP = 22;

    typedef enum logic [1:0] {
        S_IDLE, S_RUN, S_EMIT
    } state_t;

    state_t     state_reg;
    logic [4:0] step_reg;
    logic       last_reg;
    logic       ready_reg;
    logic       accept;

    assign in_ready = ready_reg;
    assign accept   = in_valid && ready_reg;

    // microcode: multiply operands, accumulate op, stores lagged by prod_reg and acc_reg
    function automatic dp_cmd_t step_cmd(input logic [4:0] s);
        dp_cmd_t c;
        c = '{write_joint: 1'b0, load_item: 1'b0, emit: 1'b0, a_sel: A_QW,
              b_sel: B_PX, acc_op: ACC_HOLD, store: ST_NONE, vsum: VS_NONE};
        unique case (s)
            5'd0:  begin c.a_sel = A_QY; c.b_sel = B_PZ; c.acc_op = ACC_LOAD; end
            5'd1:  begin c.a_sel = A_QZ; c.b_sel = B_PY; c.acc_op = ACC_SUB; end
            5'd2:  begin c.a_sel = A_QZ; c.b_sel = B_PX; c.acc_op = ACC_LOAD; end
            5'd3:  begin c.a_sel = A_QX; c.b_sel = B_PZ; c.acc_op = ACC_SUB;
                         c.store = ST_TX; end
            5'd4:  begin c.a_sel = A_QX; c.b_sel = B_PY; c.acc_op = ACC_LOAD; end
            5'd5:  begin c.a_sel = A_QY; c.b_sel = B_PX; c.acc_op = ACC_SUB;
                         c.store = ST_TY; end
            5'd6:  begin c.a_sel = A_QW; c.b_sel = B_TX; c.acc_op = ACC_LOAD; end
            5'd7:  begin c.a_sel = A_QZ; c.b_sel = B_TY; c.acc_op = ACC_SUB;
                         c.store = ST_TZ; end
            5'd8:  begin c.a_sel = A_QY; c.b_sel = B_TZ; c.acc_op = ACC_ADD; end
            5'd9:  begin c.a_sel = A_QW; c.b_sel = B_TY; c.acc_op = ACC_LOAD; end
            5'd10: begin c.a_sel = A_QZ; c.b_sel = B_TX; c.acc_op = ACC_ADD;
                         c.store = ST_WX; end
            5'd11: begin c.a_sel = A_QX; c.b_sel = B_TZ; c.acc_op = ACC_SUB;
                         c.vsum = VS_X; end
            5'd12: begin c.a_sel = A_QW; c.b_sel = B_TZ; c.acc_op = ACC_LOAD; end
            5'd13: begin c.a_sel = A_QX; c.b_sel = B_TY; c.acc_op = ACC_ADD;
                         c.store = ST_WY; end
            5'd14: begin c.a_sel = A_QY; c.b_sel = B_TX; c.acc_op = ACC_SUB;
                         c.vsum = VS_Y; end
            5'd15: begin c.a_sel = A_BIAS; c.b_sel = B_VX; c.acc_op = ACC_LOAD; end
            5'd16: begin c.a_sel = A_BIAS; c.b_sel = B_WX; c.acc_op = ACC_LOAD;
                         c.store = ST_WZ; end
            5'd17: begin c.a_sel = A_BIAS; c.b_sel = B_VY; c.acc_op = ACC_LOAD;
                         c.store = ST_AVX; c.vsum = VS_Z; end
            5'd18: begin c.a_sel = A_BIAS; c.b_sel = B_WY; c.acc_op = ACC_LOAD;
                         c.store = ST_ANX; end
            5'd19: begin c.a_sel = A_BIAS; c.b_sel = B_VZ; c.acc_op = ACC_LOAD;
                         c.store = ST_AVY; end
            5'd20: begin c.a_sel = A_BIAS; c.b_sel = B_WZ; c.acc_op = ACC_LOAD;
                         c.store = ST_ANY; end
            5'd21: c.store = ST_AVZ;
            5'd22: c.store = ST_ANZ;
            default: c.store = ST_NONE;
        endcase
        return c;
    endfunction

    always_comb
    begin
        cmd = step_cmd(5'd31);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.write_joint = accept && !in_mode;
                cmd.load_item   = accept && in_mode;
            end
            S_RUN:  cmd = step_cmd(step_reg);
            S_EMIT: cmd.emit = stat.out_free;
            default: cmd.emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            last_reg  <= 1'b0;
            ready_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    ready_reg <= 1'b1;
                    if (accept && in_mode)
                    begin
                        state_reg <= S_RUN;
                        step_reg  <= '0;
                        last_reg  <= in_last;
                        ready_reg <= 1'b0;
                    end
                end
                S_RUN:
                begin
                    if (step_reg == 5'(LAST_STEP))
                    begin
                        if (last_reg)
                            state_reg <= S_EMIT;
                        else
                        begin
                            state_reg <= S_IDLE;
                            ready_reg <= 1'b1;
                        end
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                S_EMIT:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/vsa_datapath.sv -----
// datapath of the vertex skinning accumulator: joint memory, shared
// multiply-accumulate, rotation and sum registers, output word register
// depends on vsa_pkg
module vsa_datapath #(
    parameter int MAX_JOINTS = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [vsa_pkg::S_DATA_W-1:0]     in_data,
    input  vsa_pkg::dp_cmd_t                 cmd,
    output vsa_pkg::dp_stat_t                stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [vsa_pkg::M_DATA_W-1:0]     out_data
);
    import vsa_pkg::*;

    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    // joint entry: px, py, pz, qw, qx, qy, qz from the top bits down
    logic [159:0] mem [MAX_JOINTS];
    logic [159:0] mem_rd_reg;
    logic         range_reg;

    logic [10:0]    idx_w;
    logic           in_range;
    logic [AW-1:0]  addr;

    assign idx_w    = 11'(in_data[F_IDX +: 7]);
    assign in_range = idx_w < 11'(MAX_JOINTS);
    assign addr     = idx_w[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.write_joint && in_range)
            mem[addr] <= {in_data[F_PX +: 32], in_data[F_PY +: 32], in_data[F_PZ +: 32],
                          in_data[F_QW +: 16], in_data[F_QX +: 16], in_data[F_QY +: 16],
                          in_data[F_QZ +: 16]};
        if (cmd.load_item)
        begin
            mem_rd_reg <= mem[addr];
            range_reg  <= in_range;
        end
    end

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic        [15:0] bias_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            px_reg   <= in_data[F_PX +: 32];
            py_reg   <= in_data[F_PY +: 32];
            pz_reg   <= in_data[F_PZ +: 32];
            bias_reg <= in_data[F_BIAS +: 16];
        end
    end

    // an index past the table reads as a zero joint
    logic [159:0]       joint;
    logic signed [31:0] jx, jy, jz;
    logic signed [15:0] qw, qx, qy, qz;

    assign joint = range_reg ? mem_rd_reg : '0;
    assign jx = joint[159:128];
    assign jy = joint[127:96];
    assign jz = joint[95:64];
    assign qw = joint[63:48];
    assign qx = joint[47:32];
    assign qy = joint[31:16];
    assign qz = joint[15:0];

    logic signed [T_W-1:0]    tx_reg, ty_reg, tz_reg;
    logic signed [31:0]       wx_reg, wy_reg, wz_reg;
    logic signed [32:0]       vx_reg, vy_reg, vz_reg;
    logic signed [16:0]       a_op;
    logic signed [T_W-1:0]    b_op;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    acc_op_t                  op_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    always_comb
    begin
        case (cmd.a_sel)
            A_QW:    a_op = 17'(qw);
            A_QX:    a_op = 17'(qx);
            A_QY:    a_op = 17'(qy);
            A_QZ:    a_op = 17'(qz);
            A_BIAS:  a_op = signed'({1'b0, bias_reg});
            default: a_op = '0;
        endcase
        case (cmd.b_sel)
            B_PX:    b_op = T_W'(px_reg);
            B_PY:    b_op = T_W'(py_reg);
            B_PZ:    b_op = T_W'(pz_reg);
            B_TX:    b_op = tx_reg;
            B_TY:    b_op = ty_reg;
            B_TZ:    b_op = tz_reg;
            B_VX:    b_op = T_W'(vx_reg);
            B_VY:    b_op = T_W'(vy_reg);
            B_VZ:    b_op = T_W'(vz_reg);
            B_WX:    b_op = T_W'(wx_reg);
            B_WY:    b_op = T_W'(wy_reg);
            B_WZ:    b_op = T_W'(wz_reg);
            default: b_op = '0;
        endcase
    end

    assign prod_next = a_op * b_op;

    always_comb
    begin
        case (op_reg)
            ACC_LOAD: acc_next = ACC_W'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_SUB:  acc_next = acc_reg - ACC_W'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= ACC_HOLD;
        else
            op_reg <= cmd.acc_op;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // round half up at the three output scales
    logic signed [ACC_W-1:0] acc_r13, acc_r14, acc_r15;
    logic signed [31:0]      w_sat, sum_sat;
    logic signed [31:0]      w_base, sum_base;

    assign acc_r13 = (acc_reg + ACC_W'(4096)) >>> 13;
    assign acc_r14 = (acc_reg + ACC_W'(8192)) >>> 14;
    assign acc_r15 = (acc_reg + ACC_W'(16384)) >>> 15;

    always_comb
    begin
        case (cmd.store)
            ST_WY:   w_base = py_reg;
            ST_WZ:   w_base = pz_reg;
            default: w_base = px_reg;
        endcase
    end

    assign w_sat = sat32(42'(w_base) + 42'(acc_r14));

    logic signed [31:0] vacc_x_reg, vacc_y_reg, vacc_z_reg;
    logic signed [31:0] nacc_x_reg, nacc_y_reg, nacc_z_reg;

    always_comb
    begin
        case (cmd.store)
            ST_AVY:  sum_base = vacc_y_reg;
            ST_AVZ:  sum_base = vacc_z_reg;
            ST_ANX:  sum_base = nacc_x_reg;
            ST_ANY:  sum_base = nacc_y_reg;
            ST_ANZ:  sum_base = nacc_z_reg;
            default: sum_base = vacc_x_reg;
        endcase
    end

    assign sum_sat = sat32(42'(sum_base) + 42'(acc_r15));

    always_ff @(posedge clk)
    begin
        case (cmd.store)
            ST_TX:   tx_reg <= acc_r13[T_W-1:0];
            ST_TY:   ty_reg <= acc_r13[T_W-1:0];
            ST_TZ:   tz_reg <= acc_r13[T_W-1:0];
            ST_WX:   wx_reg <= w_sat;
            ST_WY:   wy_reg <= w_sat;
            ST_WZ:   wz_reg <= w_sat;
            default: ;
        endcase
        case (cmd.vsum)
            VS_X:    vx_reg <= 33'(jx) + 33'(wx_reg);
            VS_Y:    vx_reg <= vx_reg;
            default: ;
        endcase
        case (cmd.vsum)
            VS_Y:    vy_reg <= 33'(jy) + 33'(wy_reg);
            VS_Z:    vz_reg <= 33'(jz) + 33'(wz_reg);
            default: ;
        endcase
    end

    logic               out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vacc_x_reg    <= '0;
            vacc_y_reg    <= '0;
            vacc_z_reg    <= '0;
            nacc_x_reg    <= '0;
            nacc_y_reg    <= '0;
            nacc_z_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                vacc_x_reg    <= '0;
                vacc_y_reg    <= '0;
                vacc_z_reg    <= '0;
                nacc_x_reg    <= '0;
                nacc_y_reg    <= '0;
                nacc_z_reg    <= '0;
            end
            else
            begin
                case (cmd.store)
                    ST_AVX:  vacc_x_reg <= sum_sat;
                    ST_AVY:  vacc_y_reg <= sum_sat;
                    ST_AVZ:  vacc_z_reg <= sum_sat;
                    ST_ANX:  nacc_x_reg <= sum_sat;
                    ST_ANY:  nacc_y_reg <= sum_sat;
                    ST_ANZ:  nacc_z_reg <= sum_sat;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_data_reg <= {nacc_z_reg, nacc_y_reg, nacc_x_reg,
                             vacc_z_reg, vacc_y_reg, vacc_x_reg};
    end

endmodule

// ----- hdl/vertex_skinning_accumulator_top.sv -----
// top level of the vertex skinning accumulator
// joins the sequencer and the datapath; depends on vsa_pkg, vsa_ctrl, vsa_datapath
//
//  channel  dir  signals                          word contents
//  s_*      in   s_tvalid s_tready s_tdata s_tuser s_tlast  joint write or vertex weight
//  m_*      out  m_tvalid m_tready m_tdata          skinned vertex and normal sums
//
// joint words are taken back to back; a weight word holds off the input while the
// one shared 17x36 multiplier steps through 21 products plus store slack,
// and a last weight then moves the sums into the output register
// reset clears the sums and control; the joint table is not cleared
// a finished result waits in the output register while new words are taken;
// only a second result held back by m_tready stalls the input side
module vertex_skinning_accumulator_top #(
    parameter int MAX_JOINTS = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // joint_index, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, bias, zero pad
    input  logic [vsa_pkg::S_DATA_W-1:0]   s_tdata,
    // mode: 0 joint write, 1 weight
    input  logic                           s_tuser,
    // last_weight
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z
    output logic [vsa_pkg::M_DATA_W-1:0]   m_tdata
);
    import vsa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: one step of the multiply-accumulate schedule per cycle
    vsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // joint table, multiplier, sums and output register
    vsa_datapath #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- hdl/vsa_checker.sv -----
// port-level checks for the vertex skinning accumulator, bound to the top level
// depends on vsa_pkg and vertex_skinning_accumulator_top
module vsa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [vsa_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         s_tuser,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [vsa_pkg::M_DATA_W-1:0] m_tdata
);
    // a held result keeps its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // a weight word occupies the datapath
    a_weight_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken again right after a weight word");

    // joint writes never block the input
    a_joint_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("input blocked after a joint word");

    // a new result frees the input side in the same cycle
    a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while input still blocked");

endmodule

bind vertex_skinning_accumulator_top vsa_checker u_vsa_checker (.*);

// ----- verif/tb_vertex_skinning_accumulator_top.sv -----
// self-checking testbench for the vertex skinning accumulator top level
// drives joint and weight words with random gaps, checks sums against a local predictor
// depends on vsa_pkg and vertex_skinning_accumulator_top
`timescale 1ns / 1ps

module tb_vertex_skinning_accumulator_top;
    import vsa_pkg::*;

    localparam int NJOINTS = 128;
    localparam int WATCHDOG_LIMIT = 20000;

    // input word as seen by the block
    typedef struct {
        logic              mode;
        logic [6:0]        jidx;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] qw, qx, qy, qz;
        logic [15:0]       bias;
        logic              last;
    } skin_word_t;

    typedef struct {
        logic signed [31:0] vx, vy, vz, nx, ny, nz;
    } skin_sum_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    vertex_skinning_accumulator_top #(.MAX_JOINTS(NJOINTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor copy of the joint table and running sums
    logic signed [31:0] jpos_x [NJOINTS];
    logic signed [31:0] jpos_y [NJOINTS];
    logic signed [31:0] jpos_z [NJOINTS];
    logic signed [15:0] jq_w [NJOINTS];
    logic signed [15:0] jq_x [NJOINTS];
    logic signed [15:0] jq_y [NJOINTS];
    logic signed [15:0] jq_z [NJOINTS];
    bit                 jwritten [NJOINTS];
    longint vsum_x, vsum_y, vsum_z, nsum_x, nsum_y, nsum_z;

    skin_word_t pending_words[$];
    skin_sum_t  expected_sums[$];
    int  errors = 0;
    int  words_sent = 0;
    int  sums_seen = 0;
    int  idle_cycles = 0;
    bit  hold_sender = 1'b0;

    // driver state
    skin_word_t cur_word;
    bit  word_taken = 1'b0;
    bit  gap_drawn = 1'b0;
    int  gap_left = 0;

    // append one word to the pending queue
    task automatic add_word(skin_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    // round half up by n bits on a signed value
    function automatic longint rnd_shr(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // apply one accepted word to the predictor; queue a sum on the last weight
    task automatic skin_predict(skin_word_t w);
        longint jx, jy, jz, qw, qx, qy, qz, vx, vy, vz, b;
        longint tx, ty, tz, rx, ry, rz, wx, wy, wz;
        skin_sum_t s;
        if (!w.mode)
        begin
            jpos_x[w.jidx] = w.px; jpos_y[w.jidx] = w.py; jpos_z[w.jidx] = w.pz;
            jq_w[w.jidx] = w.qw; jq_x[w.jidx] = w.qx;
            jq_y[w.jidx] = w.qy; jq_z[w.jidx] = w.qz;
            jwritten[w.jidx] = 1'b1;
            return;
        end
        jx = longint'(jpos_x[w.jidx]);
        jy = longint'(jpos_y[w.jidx]);
        jz = longint'(jpos_z[w.jidx]);
        qw = longint'(jq_w[w.jidx]); qx = longint'(jq_x[w.jidx]);
        qy = longint'(jq_y[w.jidx]); qz = longint'(jq_z[w.jidx]);
        vx = longint'(w.px); vy = longint'(w.py); vz = longint'(w.pz);
        b = longint'({48'd0, w.bias});
        tx = rnd_shr(2 * (qy * vz - qz * vy), 14);
        ty = rnd_shr(2 * (qz * vx - qx * vz), 14);
        tz = rnd_shr(2 * (qx * vy - qy * vx), 14);
        rx = rnd_shr(qw * tx + (qy * tz - qz * ty), 14);
        ry = rnd_shr(qw * ty + (qz * tx - qx * tz), 14);
        rz = rnd_shr(qw * tz + (qx * ty - qy * tx), 14);
        wx = clamp32(vx + rx); wy = clamp32(vy + ry); wz = clamp32(vz + rz);
        vsum_x = clamp32(vsum_x + rnd_shr((jx + wx) * b, 15));
        vsum_y = clamp32(vsum_y + rnd_shr((jy + wy) * b, 15));
        vsum_z = clamp32(vsum_z + rnd_shr((jz + wz) * b, 15));
        nsum_x = clamp32(nsum_x + rnd_shr(wx * b, 15));
        nsum_y = clamp32(nsum_y + rnd_shr(wy * b, 15));
        nsum_z = clamp32(nsum_z + rnd_shr(wz * b, 15));
        if (w.last)
        begin
            s.vx = 32'(vsum_x); s.vy = 32'(vsum_y); s.vz = 32'(vsum_z);
            s.nx = 32'(nsum_x); s.ny = 32'(nsum_y); s.nz = 32'(nsum_z);
            expected_sums.insert(expected_sums.size(), s);
            vsum_x = 0; vsum_y = 0; vsum_z = 0;
            nsum_x = 0; nsum_y = 0; nsum_z = 0;
        end
    endtask

    function automatic skin_word_t joint_word(int idx, logic signed [31:0] x,
                                              logic signed [31:0] y, logic signed [31:0] z,
                                              logic signed [15:0] qw, logic signed [15:0] qx,
                                              logic signed [15:0] qy, logic signed [15:0] qz);
        skin_word_t w;
        w.mode = 1'b0; w.jidx = idx[6:0];
        w.px = x; w.py = y; w.pz = z;
        w.qw = qw; w.qx = qx; w.qy = qy; w.qz = qz;
        // bias and last are don't-care on joint words, so randomize them
        w.bias = 16'($urandom); w.last = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic skin_word_t weight_word(int idx, logic signed [31:0] x,
                                               logic signed [31:0] y, logic signed [31:0] z,
                                               logic [15:0] b, logic last);
        skin_word_t w;
        w.mode = 1'b1; w.jidx = idx[6:0];
        w.px = x; w.py = y; w.pz = z;
        w.qw = 16'($urandom); w.qx = 16'($urandom);
        w.qy = 16'($urandom); w.qz = 16'($urandom);
        w.bias = b; w.last = last;
        return w;
    endfunction

    // offsets mostly modest, sometimes full range to hit saturation
    function automatic logic signed [31:0] rand_offset();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
        endcase
    endfunction

    // quaternion components within plus or minus 16384, with occasional raw values
    function automatic logic signed [15:0] rand_quat();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    // pick a joint that has been written
    function automatic int rand_written_joint();
        int j;
        do
            j = $urandom_range(0, NJOINTS - 1);
        while (!jwritten[j]);
        return j;
    endfunction

    // driver: one word at a time from the pending queue, gaps drawn per word
    always @(negedge clk)
    begin
        bit slot_free;
        slot_free = !s_tvalid || word_taken;
        if (word_taken)
        begin
            word_taken = 1'b0;
            s_tvalid <= 1'b0;
        end
        if (rst_n && slot_free)
        begin
            if (!gap_drawn && pending_words.size() != 0 && !hold_sender)
            begin
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                gap_drawn = 1'b1;
            end
            if (gap_drawn)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    cur_word = pending_words.pop_front();
                    gap_drawn = 1'b0;
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_word.mode;
                    s_tlast  <= cur_word.last;
                    s_tdata  <= {1'b0, cur_word.bias, cur_word.qz, cur_word.qy, cur_word.qx,
                                 cur_word.qw, cur_word.pz, cur_word.py, cur_word.px,
                                 cur_word.jidx};
                end
            end
        end
    end

    // accepted input words feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            skin_predict(cur_word);
            words_sent++;
            word_taken = 1'b1;
        end
    end

    // monitor: ready toggles with per-word stall, checks each accepted sum
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        skin_sum_t e;
        logic signed [31:0] got [6];
        logic signed [31:0] exp_v [6];
        if (rst_n && m_tvalid && m_tready)
        begin
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            sums_seen++;
            for (int i = 0; i < 6; i++) got[i] = m_tdata[32*i +: 32];
            if (expected_sums.size() == 0)
            begin
                $display("%0t: unexpected sum word, expected none, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                e = expected_sums.pop_front();
                exp_v = '{e.vx, e.vy, e.vz, e.nx, e.ny, e.nz};
                for (int i = 0; i < 6; i++)
                    if (got[i] !== exp_v[i])
                    begin
                        $display("%0t: sum field %0d mismatch, expected %0d, actual %0d",
                                 $time, i, exp_v[i], got[i]);
                        errors++;
                    end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // add one vertex of n weights on written joints, random content
    task automatic queue_vertex(int n);
        for (int k = 0; k < n; k++)
            add_word(weight_word(rand_written_joint(), rand_offset(),
                rand_offset(), rand_offset(),
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
                k == n - 1));
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_sums.size() != 0 || s_tvalid || gap_drawn)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // stimulus: fill every joint, directed extremes, then random vertices
    initial
    begin
        int n;
        vsum_x = 0; vsum_y = 0; vsum_z = 0; nsum_x = 0; nsum_y = 0; nsum_z = 0;
        for (int j = 0; j < NJOINTS; j++) jwritten[j] = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int j = 0; j < NJOINTS; j++)
            add_word(joint_word(j, rand_offset(), rand_offset(), rand_offset(),
                                rand_quat(), rand_quat(), rand_quat(), rand_quat()));
        // directed: identity joint, extreme joints, extreme biases, saturation
        add_word(joint_word(0, 0, 0, 0, 16'sd16384, 0, 0, 0));
        add_word(joint_word(127, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                            16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
        add_word(joint_word(1, 32'sh80000000, 32'sh7fffffff, 0,
                            16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));
        add_word(weight_word(0, 32'sh0001_0000, -32'sh0002_0000, 5, 16'd32768, 1));
        add_word(weight_word(0, 7, 8, 9, 16'd0, 1));
        add_word(weight_word(127, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                             16'hffff, 1'b0));
        add_word(weight_word(127, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                             16'hffff, 1'b0));
        add_word(weight_word(1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                             16'hffff, 1'b1));
        add_word(weight_word(1, -1, -1, -1, 16'd1, 1'b1));
        for (int k = 0; k < 3; k++)
            add_word(weight_word(0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                 16'd32768, k == 2));
        // a joint word between weights of one vertex must neither emit nor clear the sums
        add_word(weight_word(0, 32'sh0003_0000, 1, 2, 16'd16384, 1'b0));
        add_word(joint_word(2, 100, 200, 300, 0, 16'sd16384, 0, 0));
        add_word(weight_word(2, 32'sh0000_8000, 3, -3, 16'd32767, 1'b1));
        wait_drained();

        // pause until all sums are back, then random traffic in bursts
        hold_sender = 1'b1;
        wait_drained();
        hold_sender = 1'b0;
        while (words_sent + pending_words.size() < 1350)
        begin
            if ($urandom_range(0, 7) == 0)
                add_word(joint_word($urandom_range(0, NJOINTS - 1), rand_offset(),
                    rand_offset(), rand_offset(), rand_quat(), rand_quat(), rand_quat(),
                    rand_quat()));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            queue_vertex(n);
            while (pending_words.size() > 20) @(posedge clk);
        end
        wait_drained();
        repeat (60) @(posedge clk);
        $display("sent %0d joint and weight words, checked %0d vertex sums", words_sent, sums_seen);
        if (errors == 0 && expected_sums.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
